>>> rtl/npch_pkg.sv
`default_nettype none

package npch_pkg;

  localparam int PALETTE_SIZE = 11;
  localparam int COUNT_BITS   = 32;

  localparam int IDX_W     = $clog2(PALETTE_SIZE);
  localparam int NEAR_W    = 4;
  localparam int TREE_N    = 2 ** NEAR_W;
  localparam int CHAN_W    = 8;
  localparam int ABS_W     = 10;
  localparam int SQ_W      = 18;
  localparam int ABS_SUM_W = COUNT_BITS + ABS_W;
  localparam int SQ_SUM_W  = COUNT_BITS + SQ_W;
  localparam int OP_W      = 2;
  localparam int IN_DATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_PIXEL = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // packed from the top down, so abs_nearest lands in the lowest bits
  typedef struct packed {
    logic [49:0] sq_total;
    logic [41:0] abs_total;
    logic [31:0] sq_wins;
    logic [31:0] abs_wins;
    logic [31:0] pixels_counted;
    logic [17:0] sq_distance;
    logic [3:0]  sq_nearest;
    logic [9:0]  abs_distance;
    logic [3:0]  abs_nearest;
  } result_t;

  localparam int OUT_DATA_W = $bits(result_t);

  function automatic logic [23:0] palette_color(int unsigned i);
    logic [23:0] c;
    case (i)
      0:       c = 24'hFFFFFF;
      1:       c = 24'h000000;
      2:       c = 24'hFF0000;
      3:       c = 24'h00FF00;
      4:       c = 24'h0000FF;
      5:       c = 24'hFFFF00;
      6:       c = 24'h00FFFF;
      7:       c = 24'hFF00FF;
      8:       c = 24'h808080;
      9:       c = 24'hFFA500;
      10:      c = 24'h800080;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

  function automatic logic [CHAN_W-1:0] chan_diff(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

>>> rtl/nearest_palette_color_histogram.sv
// an accepted item passes the input, distance, winner and output registers in turn
// throughput: one item per cycle unless stalled; distances, nearest-entry tree and stats
//   update each take one register stage, and a skid register decouples the output
// s_tready is registered and drops only while the skid register is occupied
// rst (synchronous) clears the pipeline, the pixel count and all bin statistics
`default_nettype none

module nearest_palette_color_histogram
  import npch_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,  // red, green, blue, bin_index, zero pad
  input  wire logic [OP_W-1:0]       s_tuser,  // operation
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata   // abs_nearest, abs_distance, sq_nearest,
                                               // sq_distance, pixels_counted, abs_wins,
                                               // sq_wins, abs_total, sq_total
);

  logic en;

  // input stage
  logic              valid0;
  op_t               op0;
  logic [CHAN_W-1:0] red0, green0, blue0;
  logic [NEAR_W-1:0] bin0;

  // distance stage
  logic              valid1;
  op_t               op1;
  logic [NEAR_W-1:0] bin1;
  logic [ABS_W-1:0]  abs_dist1 [PALETTE_SIZE];
  logic [SQ_W-1:0]   sq_dist1  [PALETTE_SIZE];
  logic [ABS_W-1:0]  abs_dist1_next [PALETTE_SIZE];
  logic [SQ_W-1:0]   sq_dist1_next  [PALETTE_SIZE];

  // winner stage
  logic              valid2;
  op_t               op2;
  logic [NEAR_W-1:0] bin2;
  logic [NEAR_W-1:0] abs_best2, sq_best2;
  logic [ABS_W-1:0]  abs_min2;
  logic [SQ_W-1:0]   sq_min2;
  logic [NEAR_W-1:0] abs_best2_next, sq_best2_next;
  logic [ABS_W-1:0]  abs_min2_next;
  logic [SQ_W-1:0]   sq_min2_next;

  // statistics
  logic [COUNT_BITS-1:0] pixel_total;
  logic [COUNT_BITS-1:0] abs_win_counts    [PALETTE_SIZE];
  logic [COUNT_BITS-1:0] sq_win_counts     [PALETTE_SIZE];
  logic [ABS_SUM_W-1:0]  abs_distance_sums [PALETTE_SIZE];
  logic [SQ_SUM_W-1:0]   sq_distance_sums  [PALETTE_SIZE];

  // output and skid
  logic    out_valid, skid_valid;
  result_t out_data, skid_data, res;

  assign en       = !skid_valid;
  assign s_tready = en;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
      valid1 <= 1'b0;
      valid2 <= 1'b0;
    end else if (en) begin
      valid0 <= s_tvalid;
      valid1 <= valid0;
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op0       <= op_t'(s_tuser);
      red0      <= s_tdata[7:0];
      green0    <= s_tdata[15:8];
      blue0     <= s_tdata[23:16];
      bin0      <= s_tdata[27:24];
      op1       <= op0;
      bin1      <= bin0;
      abs_dist1 <= abs_dist1_next;
      sq_dist1  <= sq_dist1_next;
      op2       <= op1;
      bin2      <= bin1;
      abs_best2 <= abs_best2_next;
      abs_min2  <= abs_min2_next;
      sq_best2  <= sq_best2_next;
      sq_min2   <= sq_min2_next;
    end
  end

  // per-entry distances
  always_comb begin
    logic [23:0]       c;
    logic [CHAN_W-1:0] dr, dg, db;
    for (int i = 0; i < PALETTE_SIZE; i++) begin
      c  = palette_color(i);
      dr = chan_diff(red0, c[23:16]);
      dg = chan_diff(green0, c[15:8]);
      db = chan_diff(blue0, c[7:0]);
      abs_dist1_next[i] = ABS_W'(dr) + ABS_W'(dg) + ABS_W'(db);
      sq_dist1_next[i]  = SQ_W'(16'(dr) * 16'(dr)) + SQ_W'(16'(dg) * 16'(dg))
                        + SQ_W'(16'(db) * 16'(db));
    end
  end

  // min tree, left (lower index) wins ties
  always_comb begin
    logic [ABS_W-1:0]  a_node [1:2*TREE_N-1];
    logic [NEAR_W-1:0] a_idx  [1:2*TREE_N-1];
    logic [SQ_W-1:0]   q_node [1:2*TREE_N-1];
    logic [NEAR_W-1:0] q_idx  [1:2*TREE_N-1];
    for (int i = 0; i < TREE_N; i++) begin
      a_idx[TREE_N+i] = NEAR_W'(i);
      q_idx[TREE_N+i] = NEAR_W'(i);
      if (i < PALETTE_SIZE) begin
        a_node[TREE_N+i] = abs_dist1[i];
        q_node[TREE_N+i] = sq_dist1[i];
      end else begin
        a_node[TREE_N+i] = '1;
        q_node[TREE_N+i] = '1;
      end
    end
    for (int k = TREE_N - 1; k >= 1; k--) begin
      if (a_node[2*k+1] < a_node[2*k]) begin
        a_node[k] = a_node[2*k+1];
        a_idx[k]  = a_idx[2*k+1];
      end else begin
        a_node[k] = a_node[2*k];
        a_idx[k]  = a_idx[2*k];
      end
      if (q_node[2*k+1] < q_node[2*k]) begin
        q_node[k] = q_node[2*k+1];
        q_idx[k]  = q_idx[2*k+1];
      end else begin
        q_node[k] = q_node[2*k];
        q_idx[k]  = q_idx[2*k];
      end
    end
    abs_best2_next = a_idx[1];
    abs_min2_next  = a_node[1];
    sq_best2_next  = q_idx[1];
    sq_min2_next   = q_node[1];
  end

  // statistics update and result
  logic                  sat, upd_pixel, upd_clear, rd_ok;
  logic [IDX_W-1:0]      abs_idx, sq_idx, rd_idx;
  logic [COUNT_BITS-1:0] pix_after;

  assign sat       = (pixel_total == '1);
  assign upd_pixel = en && valid2 && (op2 == OP_PIXEL) && !sat;
  assign upd_clear = en && valid2 && (op2 == OP_CLEAR);
  assign abs_idx   = abs_best2[IDX_W-1:0];
  assign sq_idx    = sq_best2[IDX_W-1:0];
  assign rd_idx    = bin2[IDX_W-1:0];
  assign rd_ok     = (int'(bin2) < PALETTE_SIZE);

  always_comb begin
    res = '0;
    unique case (op2)
      OP_PIXEL: begin
        pix_after        = sat ? pixel_total : pixel_total + 1'b1;
        res.abs_nearest  = abs_best2;
        res.abs_distance = abs_min2;
        res.sq_nearest   = sq_best2;
        res.sq_distance  = sq_min2;
      end
      OP_READ: begin
        pix_after = pixel_total;
        if (rd_ok) begin
          res.abs_wins  = 32'(abs_win_counts[rd_idx]);
          res.sq_wins   = 32'(sq_win_counts[rd_idx]);
          res.abs_total = 42'(abs_distance_sums[rd_idx]);
          res.sq_total  = 50'(sq_distance_sums[rd_idx]);
        end
      end
      OP_CLEAR: pix_after = '0;
      default:  pix_after = pixel_total;
    endcase
    res.pixels_counted = 32'(pix_after);
  end

  always_ff @(posedge clk) begin
    if (rst || upd_clear) begin
      pixel_total <= '0;
      for (int i = 0; i < PALETTE_SIZE; i++) begin
        abs_win_counts[i]    <= '0;
        sq_win_counts[i]     <= '0;
        abs_distance_sums[i] <= '0;
        sq_distance_sums[i]  <= '0;
      end
    end else if (upd_pixel) begin
      pixel_total               <= pixel_total + 1'b1;
      abs_win_counts[abs_idx]   <= abs_win_counts[abs_idx] + 1'b1;
      sq_win_counts[sq_idx]     <= sq_win_counts[sq_idx] + 1'b1;
      abs_distance_sums[abs_idx] <= abs_distance_sums[abs_idx] + ABS_SUM_W'(abs_min2);
      sq_distance_sums[sq_idx]  <= sq_distance_sums[sq_idx] + SQ_SUM_W'(sq_min2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !m_tready) begin
      if (en && valid2) begin
        skid_valid <= 1'b1;
        skid_data  <= res;
      end
    end else if (skid_valid) begin
      out_data   <= skid_data;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= valid2;
      if (valid2) begin
        out_data <= res;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/npch_checker.sv
`default_nettype none

module npch_checker
  import npch_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata
);

  result_t r;
  logic    in_busy;

  assign r       = result_t'(m_tdata);
  assign in_busy = s_tvalid && !s_tready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // input side only backs up when a result is waiting
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_busy |-> m_tvalid && $past(m_tvalid && !m_tready))
    else $error("input stalled with no waiting result");

  // a read result never carries classification fields, and vice versa
  a_fields_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (r.abs_wins != 0 || r.sq_wins != 0 || r.abs_total != 0 || r.sq_total != 0)
    |-> r.abs_nearest == 0 && r.abs_distance == 0 && r.sq_nearest == 0 && r.sq_distance == 0)
    else $error("read and pixel fields both set");

  a_nearest_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> int'(r.abs_nearest) < PALETTE_SIZE && int'(r.sq_nearest) < PALETTE_SIZE
                 && r.sq_distance >= 18'(r.abs_distance))
    else $error("nearest index or distance out of range");

endmodule

bind nearest_palette_color_histogram npch_checker u_npch_checker (.*);

`default_nettype wire
